// ----- src/sfil_pkg.sv -----
// Shared types, codes and face arithmetic for the strip face index locator.
package sfil_pkg;

  localparam int MAX_STRIPS_DEF = 64;
  localparam int INDEX_BITS_DEF = 16;

  // Drawing modes
  localparam logic [2:0] DRAW_TRIANGLES  = 3'd0;
  localparam logic [2:0] DRAW_TRI_STRIP  = 3'd1;
  localparam logic [2:0] DRAW_TRI_FAN    = 3'd2;
  localparam logic [2:0] DRAW_LINES      = 3'd3;
  localparam logic [2:0] DRAW_LINE_STRIP = 3'd4;
  localparam logic [2:0] DRAW_LINE_LOOP  = 3'd5;
  localparam logic [2:0] DRAW_POINTS     = 3'd6;

  // Actions
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_COUNT  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_DRAWING_MODE   = 2'd0;
  localparam logic [1:0] CFG_STRIPS_IN_USE  = 2'd1;
  localparam logic [1:0] CFG_TOTAL_VERTICES = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  strip_slot;
    logic [15:0] strip_length;
    logic [15:0] face_number;
  } in_item_t;

  typedef struct packed {
    logic [15:0] vertex_a;
    logic [15:0] vertex_b;
    logic [15:0] vertex_c;
    logic [15:0] face_total;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic step;
    logic capture;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
  } dp_sts_t;

  typedef struct packed {
    logic [17:0] a;
    logic [17:0] b;
    logic [17:0] c;
  } rel_vtx_t;

  // Faces held by a run of n vertices; n/3 by reciprocal multiply.
  function automatic logic [15:0] faces_of(input logic [2:0] mode, input logic [15:0] n);
    logic [32:0] prod;
    logic [15:0] res;
    prod = 33'(n) * 33'd43691;
    res  = '0;
    unique case (mode)
      DRAW_TRIANGLES:    res = prod[32:17];
      DRAW_TRI_STRIP,
      DRAW_TRI_FAN:      res = (n > 16'd2) ? n - 16'd2 : 16'd0;
      DRAW_LINES:        res = {1'b0, n[15:1]};
      DRAW_LINE_STRIP:   res = (n > 16'd1) ? n - 16'd1 : 16'd0;
      DRAW_LINE_LOOP,
      DRAW_POINTS:       res = n;
      default:           res = '0;
    endcase
    return res;
  endfunction

  // Vertex indices of face f within a run of len vertices, relative to its start.
  function automatic rel_vtx_t face_in_run(input logic [2:0] mode, input logic [15:0] f,
                                           input logic [15:0] len);
    rel_vtx_t    v;
    logic [17:0] f1;
    logic [17:0] f2;
    logic [17:0] x2;
    logic [17:0] x3;
    v  = '0;
    f1 = 18'(f) + 18'd1;
    f2 = 18'(f) + 18'd2;
    x2 = 18'({f, 1'b0});
    x3 = 18'({f, 1'b0}) + 18'(f);
    unique case (mode)
      DRAW_TRIANGLES: begin
        v.a = x3; v.b = x3 + 18'd1; v.c = x3 + 18'd2;
      end
      DRAW_TRI_STRIP: begin
        v.a = 18'(f);
        if (!f[0]) begin
          v.b = f1; v.c = f2;
        end else begin
          v.b = f2; v.c = f1;
        end
      end
      DRAW_TRI_FAN: begin
        v.b = f1; v.c = f2;
      end
      DRAW_LINES: begin
        v.a = x2; v.b = x2 + 18'd1;
      end
      DRAW_LINE_STRIP: begin
        v.a = 18'(f); v.b = f1;
      end
      DRAW_LINE_LOOP: begin
        v.a = 18'(f);
        v.b = (f1 < 18'(len)) ? f1 : 18'd0;
      end
      DRAW_POINTS: v.a = 18'(f);
      default:     v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/sfil_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sfil_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/sfil_ctrl.sv -----
// Controller: sequences write, scan and result delivery for one item at a time.
module sfil_ctrl #(
  parameter int MAX_STRIPS = sfil_pkg::MAX_STRIPS_DEF,
  parameter int AW         = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1,
  parameter int CNT_W      = $clog2(MAX_STRIPS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_action,
  output logic              in_stall,
  input  logic [CNT_W-1:0]  n_strips,
  input  sfil_pkg::dp_sts_t sts,
  output sfil_pkg::dp_cmd_t cmd,
  output logic [AW-1:0]     rd_idx,
  output logic              out_valid,
  input  logic              out_stall
);
  import sfil_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PRIME = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc, rd_cnt;
  logic [1:0]       act_r, act_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign cnt_inc  = cnt_r + 1'b1;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    act_nxt   = act_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          act_nxt   = in_action;
          cnt_nxt   = '0;
          if ((in_action == ACT_LOOKUP || in_action == ACT_COUNT) && n_strips != '0) begin
            state_nxt = S_PRIME;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_PRIME: state_nxt = S_SCAN;
      S_SCAN: begin
        if (act_r == ACT_LOOKUP && sts.hit) begin
          cmd.capture = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_inc;
          if (cnt_inc == n_strips) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Read one entry ahead while scanning so each cycle sees a fresh entry.
  assign rd_cnt = (state_r == S_SCAN) ? cnt_inc : cnt_r;
  assign rd_idx = rd_cnt[AW-1:0];

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- src/sfil_dp.sv -----
// Datapath: configuration, strip table, scan accumulators and result register.
module sfil_dp #(
  parameter int MAX_STRIPS = sfil_pkg::MAX_STRIPS_DEF,
  parameter int INDEX_BITS = sfil_pkg::INDEX_BITS_DEF,
  parameter int AW         = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1,
  parameter int CNT_W      = $clog2(MAX_STRIPS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  sfil_pkg::in_item_t  in_data,
  input  sfil_pkg::dp_cmd_t   cmd,
  input  logic [AW-1:0]       rd_idx,
  output sfil_pkg::dp_sts_t   sts,
  output logic [CNT_W-1:0]    n_strips,
  output sfil_pkg::out_item_t out_data
);
  import sfil_pkg::*;

  localparam int ACC_W = 16 + CNT_W;
  localparam logic [63:0] IDX_MASK = (64'd1 << INDEX_BITS) - 64'd1;
  localparam logic [15:0] MASK16   = IDX_MASK[15:0];

  logic [2:0]  mode_r;
  logic [6:0]  siu_r;
  logic [15:0] tv_r;

  logic [1:0]  action_r;
  logic [15:0] face_r;
  logic [15:0] fb_r;
  logic [15:0] vb_r;
  logic [ACC_W-1:0] acc_r;
  logic        found_r;
  logic [15:0] cap_a_r, cap_b_r, cap_c_r;
  out_item_t   out_r;

  logic [31:0] n32;
  logic        mono;
  logic        ram_we;
  logic [15:0] rdata;
  logic [15:0] f_sel, len_sel, base;
  rel_vtx_t    rel;
  logic [15:0] fo;
  logic [16:0] fnext;
  logic [15:0] va, vbx, vc;
  logic [ACC_W-1:0] total_sel;
  logic [63:0] tot64, tot_sat;
  out_item_t   res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      siu_r  <= '0;
      tv_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DRAWING_MODE:   mode_r <= cfg_data[2:0];
        CFG_STRIPS_IN_USE:  siu_r  <= cfg_data[6:0];
        CFG_TOTAL_VERTICES: tv_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the strip count to the table depth.
  assign n32      = (32'(siu_r) > 32'(MAX_STRIPS)) ? 32'(MAX_STRIPS) : 32'(siu_r);
  assign n_strips = n32[CNT_W-1:0];
  assign mono     = (n_strips == '0);

  assign ram_we = cmd.start && (in_data.action == ACT_WRITE)
                  && (32'(in_data.strip_slot) < 32'(MAX_STRIPS));

  sfil_ram #(.WIDTH(16), .DEPTH(MAX_STRIPS), .AW(AW)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_data.strip_slot)),
    .wdata (in_data.strip_length & MASK16),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  // One shared face unit: table entry when strips are in use, whole array when none are.
  assign f_sel   = mono ? face_r : face_r - fb_r;
  assign len_sel = mono ? tv_r : rdata;
  assign base    = mono ? 16'd0 : vb_r;
  assign rel     = face_in_run(mode_r, f_sel, len_sel);
  assign fo      = faces_of(mode_r, len_sel);
  assign fnext   = 17'(fb_r) + 17'(fo);
  assign sts.hit = fnext > 17'(face_r);

  assign va  = (rel.a[15:0] + base) & MASK16;
  assign vbx = (rel.b[15:0] + base) & MASK16;
  assign vc  = (rel.c[15:0] + base) & MASK16;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      action_r <= in_data.action;
      face_r   <= in_data.face_number;
      fb_r     <= '0;
      vb_r     <= '0;
      acc_r    <= '0;
      found_r  <= 1'b0;
    end else if (cmd.step) begin
      fb_r  <= fnext[15:0];
      vb_r  <= vb_r + rdata;
      acc_r <= acc_r + ACC_W'(fo);
    end else if (cmd.capture) begin
      found_r <= 1'b1;
      cap_a_r <= va;
      cap_b_r <= vbx;
      cap_c_r <= vc;
    end
  end

  assign total_sel = mono ? ACC_W'(fo) : acc_r;
  assign tot64     = 64'(total_sel);
  assign tot_sat   = (tot64 > IDX_MASK) ? IDX_MASK : tot64;

  always_comb begin
    res = '0;
    unique case (action_r)
      ACT_LOOKUP: begin
        if (mono) begin
          res.vertex_a = va;
          res.vertex_b = vbx;
          res.vertex_c = vc;
        end else if (found_r) begin
          res.vertex_a = cap_a_r;
          res.vertex_b = cap_b_r;
          res.vertex_c = cap_c_r;
        end else begin
          res.status = 1'b1;
        end
      end
      ACT_COUNT: res.face_total = tot_sat[15:0];
      default:   res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= res;
    end
  end

  assign out_data = out_r;

endmodule

// ----- src/strip_face_index_locator_unit.sv -----
// Top level of the strip face index locator: controller, datapath and strip table.
//
// Usage:
//   Input beats (in_valid/in_stall/in_data) carry an action: write one strip
//   length into the table, look up the three vertex indices of a face, or
//   report the total face count. Every beat gives exactly one result beat on
//   out_valid/out_stall/out_data; status flags a face beyond all strips.
//   The cfg_ port writes drawing mode, strips in use or total vertices, one
//   register per write as cfg_index selects; write it only while the block
//   is idle. A write, or a lookup or count with no strips in use, goes from
//   accept straight to the result stage. With n strips in use a count reads
//   all n table entries and a lookup reads entries up to the hit (at most n).
//   The scan reads one table entry per cycle from the single RAM read port,
//   so that port sets the rate; the block works on one item at a time.
//   in_stall is high while an item is in work; the next beat is taken while
//   a finished result still waits in the output register.
//   When the receiver stalls, the result holds and the block waits before
//   loading a further one. Synchronous reset (rst_n low) clears the
//   configuration and control state; table contents stay undefined until
//   written.
module strip_face_index_locator_unit #(
  parameter int MAX_STRIPS = sfil_pkg::MAX_STRIPS_DEF,
  parameter int INDEX_BITS = sfil_pkg::INDEX_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfil_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sfil_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import sfil_pkg::*;

  // Table address and scan counter widths follow the table depth.
  localparam int AW    = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1;
  localparam int CNT_W = $clog2(MAX_STRIPS + 1);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [AW-1:0]    rd_idx;
  logic [CNT_W-1:0] n_strips;

  // Controller: accept, scan sequencing and output handshake.
  sfil_ctrl #(.MAX_STRIPS(MAX_STRIPS), .AW(AW), .CNT_W(CNT_W)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_stall  (in_stall),
    .n_strips  (n_strips),
    .sts       (sts),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // Datapath: configuration registers, strip table, accumulators, result beat.
  sfil_dp #(
    .MAX_STRIPS (MAX_STRIPS),
    .INDEX_BITS (INDEX_BITS),
    .AW         (AW),
    .CNT_W      (CNT_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .sts       (sts),
    .n_strips  (n_strips),
    .out_data  (out_data)
  );

endmodule
